// ===== hdl/sfpr_pkg.sv =====
package sfpr_pkg;

    localparam int SYNC_BYTES  = 4;
    localparam int FIELD_BYTES = 5;
    localparam int FIELD_COUNT = 12;
    localparam int CRC_FIELD   = 11;

    localparam int PKT_BYTES = FIELD_COUNT * FIELD_BYTES;
    localparam int POS_W     = $clog2(PKT_BYTES);
    localparam int FLD_W     = $clog2(FIELD_COUNT);
    localparam int OFF_W     = $clog2(FIELD_BYTES);

    localparam logic [15:0] CRC_INIT = 16'h1D0F;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [2:0] SILENCE_MAX = 3'd7;

    localparam logic [FLD_W-1:0] FLD_INFO  = FLD_W'(1);
    localparam logic [FLD_W-1:0] FLD_IO    = FLD_W'(2);
    localparam logic [FLD_W-1:0] FLD_COLLO = FLD_W'(3);
    localparam logic [FLD_W-1:0] FLD_COLHI = FLD_W'(4);
    localparam logic [FLD_W-1:0] FLD_QC    = FLD_W'(5);
    localparam logic [FLD_W-1:0] FLD_CRC   = FLD_W'(CRC_FIELD);
    localparam logic [FLD_W-1:0] FLD_LAST  = FLD_W'(FIELD_COUNT - 1);
    localparam logic [OFF_W-1:0] OFF_LAST  = OFF_W'(FIELD_BYTES - 1);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC      = 3'd0,
        CFG_DELIMITER = 3'd1,
        CFG_TERMINATOR = 3'd2,
        CFG_SILENCE   = 3'd3,
        CFG_DATA_CODE = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_OTHER   = 2'd1,
        KIND_REJECT  = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] info;
        logic [15:0] buttons;
        logic        interlock;
        logic [31:0] col_lo;
        logic [31:0] col_hi;
        logic [15:0] diode_a;
        logic [15:0] diode_b;
    } result_t;

    // CRC-16 CCITT, one byte, MSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hdl/sfpr_if.sv =====
interface sfpr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface sfpr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] packet_info;
    logic [15:0] buttons;
    logic        interlock;
    logic [31:0] collimator_low;
    logic [31:0] collimator_high;
    logic [15:0] diode_first;
    logic [15:0] diode_second;

    modport source (output valid, output result_kind, output packet_info, output buttons,
                    output interlock, output collimator_low, output collimator_high,
                    output diode_first, output diode_second, input ready);
    modport sink   (input valid, input result_kind, input packet_info, input buttons,
                    input interlock, input collimator_low, input collimator_high,
                    input diode_first, input diode_second, output ready);
endinterface

interface sfpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sync_framed_packet_receiver.sv =====
// Sync-framed packet receiver. Each input word is either a received UART byte or a
// silence-timer tick; one word is taken per clock while din.ready is high. The packet
// state (position, running CRC-16 CCITT, field words, framing flag) is updated in the
// cycle the word is accepted, and a result (data packet, other packet, rejected packet
// or timeout fault) is written into the output register at the same clock edge as
// that update. din.ready stays high while that register is empty or being drained, so
// the input stalls only in cycles where a result waits on a stalled output, and then
// for every word, including ones that yield no result. The CRC byte update is the
// longest path. No clearing pass after reset; configuration writes are always taken.
module sync_framed_packet_receiver (
    input  logic       clk,
    input  logic       rst_n,
    sfpr_cfg_if.sink   cfg,
    sfpr_in_if.sink    din,
    sfpr_out_if.source dout
);
    import sfpr_pkg::*;

    logic [7:0]       sync_reg;
    logic [7:0]       delim_reg;
    logic [7:0]       term_reg;
    logic [2:0]       limit_reg;
    logic [31:0]      code_reg;

    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [FLD_W-1:0] fld_reg,     fld_next;
    logic [OFF_W-1:0] off_reg,     off_next;
    logic [15:0]      crc_reg,     crc_next;
    logic             good_reg,    good_next;
    logic [31:0]      crcw_reg,    crcw_next;
    logic [31:0]      info_reg,    info_next;
    logic [31:0]      io_reg,      io_next;
    logic [31:0]      collo_reg,   collo_next;
    logic [31:0]      colhi_reg,   colhi_next;
    logic [31:0]      diode_reg,   diode_next;
    logic [2:0]       silence_reg, silence_next;

    result_t          res_reg, res_next;
    logic             res_valid_reg;
    logic             res_load;

    logic             accept;
    logic [15:0]      crc_base;
    logic             good_base;
    logic [15:0]      crc_upd;
    logic             last_byte;
    logic [7:0]       b;

    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [OFF_W-1:0] off,
                                             input logic [7:0] v);
        logic [31:0] r;
        r = w;
        if (off == '0)
            r = {24'h000000, v};
        else if (off < OFF_W'(4))
            r[{off[1:0], 3'b000} +: 8] = v;
        return r;
    endfunction

    assign cfg.ready = 1'b1;
    assign din.ready = !res_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;
    assign b         = din.rx_byte;

    assign crc_base  = (pos_reg == '0) ? CRC_INIT : crc_reg;
    assign good_base = (pos_reg == '0) ? 1'b1 : good_reg;
    assign crc_upd   = crc_update(crc_base, b);
    assign last_byte = (fld_reg == FLD_LAST) && (off_reg == OFF_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg  <= 8'h00;
            delim_reg <= 8'h00;
            term_reg  <= 8'h00;
            limit_reg <= 3'd2;
            code_reg  <= 32'h00000088;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SYNC:       sync_reg  <= cfg.data[7:0];
                CFG_DELIMITER:  delim_reg <= cfg.data[7:0];
                CFG_TERMINATOR: term_reg  <= cfg.data[7:0];
                CFG_SILENCE:    limit_reg <= cfg.data[2:0];
                CFG_DATA_CODE:  code_reg  <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        fld_next     = fld_reg;
        off_next     = off_reg;
        crc_next     = crc_reg;
        good_next    = good_reg;
        crcw_next    = crcw_reg;
        info_next    = info_reg;
        io_next      = io_reg;
        collo_next   = collo_reg;
        colhi_next   = colhi_reg;
        diode_next   = diode_reg;
        silence_next = silence_reg;
        res_load     = 1'b0;
        res_next     = '0;

        if (accept)
        begin
            if (din.mode)
            begin
                if (silence_reg != SILENCE_MAX)
                    silence_next = silence_reg + 3'd1;
                if (silence_next > limit_reg)
                begin
                    res_load      = 1'b1;
                    res_next.kind = KIND_TIMEOUT;
                end
            end
            else if (pos_reg < POS_W'(SYNC_BYTES) && b != sync_reg)
            begin
                // still hunting for sync
                pos_next  = '0;
                fld_next  = '0;
                off_next  = '0;
                crc_next  = CRC_INIT;
                good_next = 1'b1;
            end
            else
            begin
                crc_next  = (fld_reg < FLD_CRC) ? crc_upd : crc_base;
                good_next = good_base;
                if (off_reg == OFF_LAST && fld_reg < FLD_LAST && b != delim_reg)
                    good_next = 1'b0;
                if (last_byte && b != term_reg)
                    good_next = 1'b0;

                case (fld_reg)
                    FLD_INFO:  info_next  = put_byte(info_reg, off_reg, b);
                    FLD_IO:    io_next    = put_byte(io_reg, off_reg, b);
                    FLD_COLLO: collo_next = put_byte(collo_reg, off_reg, b);
                    FLD_COLHI: colhi_next = put_byte(colhi_reg, off_reg, b);
                    FLD_QC:    diode_next = put_byte(diode_reg, off_reg, b);
                    default:   ;
                endcase
                if (fld_reg == FLD_CRC)
                    crcw_next = put_byte(crcw_reg, off_reg, b);

                if (!last_byte)
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (off_reg == OFF_LAST)
                    begin
                        off_next = '0;
                        fld_next = fld_reg + FLD_W'(1);
                    end
                    else
                    begin
                        off_next = off_reg + OFF_W'(1);
                    end
                end
                else
                begin
                    pos_next      = '0;
                    fld_next      = '0;
                    off_next      = '0;
                    silence_next  = 3'd0;
                    res_load      = 1'b1;
                    res_next.info = info_next;
                    // CRC field is 32 bits wide, upper half must be zero
                    if (!good_next || crcw_next != {16'h0000, crc_next})
                    begin
                        res_next.kind = KIND_REJECT;
                    end
                    else if (info_next == code_reg)
                    begin
                        res_next.kind      = KIND_DATA;
                        res_next.buttons   = io_next[15:0];
                        res_next.interlock = io_next[16];
                        res_next.col_lo    = collo_next;
                        res_next.col_hi    = colhi_next;
                        res_next.diode_a   = diode_next[15:0];
                        res_next.diode_b   = diode_next[31:16];
                    end
                    else
                    begin
                        res_next.kind = KIND_OTHER;
                    end
                    crc_next  = CRC_INIT;
                    good_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fld_reg       <= '0;
            off_reg       <= '0;
            crc_reg       <= CRC_INIT;
            good_reg      <= 1'b1;
            crcw_reg      <= 32'h0;
            info_reg      <= 32'h0;
            io_reg        <= 32'h0;
            collo_reg     <= 32'h0;
            colhi_reg     <= 32'h0;
            diode_reg     <= 32'h0;
            silence_reg   <= 3'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            fld_reg     <= fld_next;
            off_reg     <= off_next;
            crc_reg     <= crc_next;
            good_reg    <= good_next;
            crcw_reg    <= crcw_next;
            info_reg    <= info_next;
            io_reg      <= io_next;
            collo_reg   <= collo_next;
            colhi_reg   <= colhi_next;
            diode_reg   <= diode_next;
            silence_reg <= silence_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (dout.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res_next;
    end

    assign dout.valid           = res_valid_reg;
    assign dout.result_kind     = res_reg.kind;
    assign dout.packet_info     = res_reg.info;
    assign dout.buttons         = res_reg.buttons;
    assign dout.interlock       = res_reg.interlock;
    assign dout.collimator_low  = res_reg.col_lo;
    assign dout.collimator_high = res_reg.col_hi;
    assign dout.diode_first     = res_reg.diode_a;
    assign dout.diode_second    = res_reg.diode_b;

endmodule
